>>> hw/rtl/aesc_pkg.sv
// Package for the AES-256 block engine: payload structs, S-box tables and
// the GF(2^8) helpers shared by the round cells and the key cells.
`default_nettype none
package aesc_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumStages = NumRounds + 1;
  localparam int unsigned KeyIdxW = 2;
  localparam int unsigned SchedSteps = 7;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_req_t;

  // Per-stage payload handed from cell to cell.
  typedef struct packed {
    logic         kind;
    logic [127:0] st;
    logic [255:0] key;
    logic [7:0]   rc;
  } stage_t;

  localparam logic [7:0] RconFirst = 8'h01;
  localparam logic [7:0] RconLast  = 8'h80;

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] xt_back(input logic [7:0] v);
    xt_back = {1'b0, v[7:1]} ^ (v[0] ? 8'h8d : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  // Byte i of a vector with byte 0 most significant.
  function automatic logic [7:0] kb(input logic [255:0] k, input int i);
    kb = k[255-8*i -: 8];
  endfunction

  // One forward step of the Rijndael 256-bit key schedule.
  function automatic logic [255:0] sched_fwd(input logic [255:0] k, input logic [7:0] rc);
    logic [7:0] b [32];
    logic [255:0] r;
    for (int i = 0; i < 32; i++) b[i] = kb(k, i);
    b[0] = b[0] ^ sbox(b[29]) ^ rc;
    b[1] = b[1] ^ sbox(b[30]);
    b[2] = b[2] ^ sbox(b[31]);
    b[3] = b[3] ^ sbox(b[28]);
    for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
    for (int i = 16; i < 20; i++) b[i] = b[i] ^ sbox(b[i-4]);
    for (int i = 20; i < 32; i++) b[i] = b[i] ^ b[i-4];
    for (int i = 0; i < 32; i++) r[255-8*i -: 8] = b[i];
    sched_fwd = r;
  endfunction

  // One backward step; rc is the already stepped-back round constant.
  function automatic logic [255:0] sched_back(input logic [255:0] k, input logic [7:0] rc);
    logic [7:0] b [32];
    logic [255:0] r;
    for (int i = 0; i < 32; i++) b[i] = kb(k, i);
    for (int i = 31; i >= 20; i--) b[i] = b[i] ^ b[i-4];
    for (int i = 16; i < 20; i++) b[i] = b[i] ^ sbox(b[i-4]);
    for (int i = 15; i >= 4; i--) b[i] = b[i] ^ b[i-4];
    b[0] = b[0] ^ sbox(b[29]) ^ rc;
    b[1] = b[1] ^ sbox(b[30]);
    b[2] = b[2] ^ sbox(b[31]);
    b[3] = b[3] ^ sbox(b[28]);
    for (int i = 0; i < 32; i++) r[255-8*i -: 8] = b[i];
    sched_back = r;
  endfunction

  function automatic logic [127:0] sub_fwd(input logic [127:0] s);
    for (int i = 0; i < 16; i++) sub_fwd[127-8*i -: 8] = sbox(s[127-8*i -: 8]);
  endfunction

  function automatic logic [127:0] sub_inv(input logic [127:0] s);
    for (int i = 0; i < 16; i++) sub_inv[127-8*i -: 8] = inv_sbox(s[127-8*i -: 8]);
  endfunction

  // Row r rotates left by r*dir columns.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input int dir);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        shift_rows[127-8*(c*4+r) -: 8] = s[127-8*((((c + r*dir) % 4)*4) + r) -: 8];
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      mix_fwd[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      mix_fwd[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      mix_fwd[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      mix_fwd[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
  endfunction

  // Inverse mix: premultiply by (5,0,4,0) then forward mix.
  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3, u, v;
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      t[127-32*c -: 8] = a0 ^ u;
      t[119-32*c -: 8] = a1 ^ v;
      t[111-32*c -: 8] = a2 ^ u;
      t[103-32*c -: 8] = a3 ^ v;
    end
    mix_inv = mix_fwd(t);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/aesc_key_cell.sv
// One forward key-schedule cell of the chain that derives the final key state.
// Depends on aesc_pkg.
`default_nettype none
module aesc_key_cell
  import aesc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic [255:0] key_in,
  input  wire logic [7:0]   rc_in,
  output logic      [255:0] key_out,
  output logic      [7:0]   rc_out
);

  // Each cell applies one schedule step and hands it on next cycle.
  always_ff @(posedge clk) begin
    key_out <= sched_fwd(key_in, rc_in);
    rc_out  <= xt(rc_in);
  end

endmodule
`default_nettype wire

>>> hw/rtl/aesc_round_cell.sv
// One AES round cell: a full encrypt or decrypt round plus the on-the-fly
// key step for that round. Depends on aesc_pkg.
`default_nettype none
module aesc_round_cell
  import aesc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   en,
  input  wire logic   last,
  input  wire logic   odd,
  input  wire stage_t d,
  output stage_t      q
);

  stage_t nxt;
  logic [127:0] s;
  logic [255:0] k2;
  logic [7:0]   rc2;

  // Encrypt: sub, shift, mix, add; the last cell skips the mix. Decrypt: add, mix,
  // shift, sub with the inverse schedule; the last decrypt cell adds the closing key only.
  always_comb begin
    nxt = d;
    k2  = d.key;
    rc2 = d.rc;
    s   = d.st;
    if (!d.kind) begin
      s = shift_rows(sub_fwd(d.st), 1);
      if (!last) s = mix_fwd(s);
      if (odd && !last) begin
        s = s ^ d.key[127:0];
      end else begin
        k2  = sched_fwd(d.key, d.rc);
        rc2 = xt(d.rc);
        s   = s ^ k2[255:128];
      end
    end else if (last) begin
      s = d.st ^ d.key[255:128];
    end else begin
      if (odd) begin
        rc2 = xt_back(d.rc);
        k2  = sched_back(d.key, rc2);
        s   = d.st ^ k2[127:0];
      end else begin
        s = d.st ^ d.key[255:128];
      end
      s = sub_inv(shift_rows(mix_inv(s), 3));
    end
    nxt.st  = s;
    nxt.key = k2;
    nxt.rc  = rc2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/aes_block_encrypt_decrypt_top.sv
// AES-256 ECB engine, one 15-cell round pipeline.
// A request accepted into the input cell passes the 14 round cells before its result
// is valid. Throughput: one block per cycle; the chain advances unless the last cell
// holds a stalled result. The input also stalls after reset or a key write while the
// final schedule state settles through the 7-cell key chain.
// Reset: synchronous rst clears all valid bits and the key to zero.
`default_nettype none
module aes_block_encrypt_decrypt_top
  import aesc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire in_req_t        in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output out_req_t            out_data,
  input  wire logic           cfg_we,
  input  wire logic [KeyIdxW:0] cfg_index,
  input  wire logic [63:0]    cfg_data
);

  logic [255:0] key;
  logic [255:0] kc [SchedSteps + 1];
  logic [7:0]   rcc [SchedSteps + 1];
  stage_t       st [NumStages];
  logic [NumStages-1:0] vld;
  logic         adv;
  logic [2:0]   key_settle;

  // Key registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we && !cfg_index[KeyIdxW]) begin
      key[255 - 64*cfg_index[KeyIdxW-1:0] -: 64] <= cfg_data;
    end
  end

  // Count down while the key chain catches up with a new key.
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && !cfg_index[KeyIdxW])) begin
      key_settle <= 3'(SchedSteps);
    end else if (key_settle != 3'd0) begin
      key_settle <= key_settle - 3'd1;
    end
  end

  // Seven-cell forward schedule chain giving the final key state.
  assign kc[0]  = key;
  assign rcc[0] = RconFirst;
  for (genvar g = 0; g < SchedSteps; g++) begin : g_key
    aesc_key_cell u_kc (
      .clk    (clk),
      .key_in (kc[g]),
      .rc_in  (rcc[g]),
      .key_out(kc[g+1]),
      .rc_out (rcc[g+1])
    );
  end

  // Whole pipe moves unless the output holds an unaccepted result.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || (key_settle != 3'd0);

  // Entry cell: initial key add, plus inverse shift and sub for decrypt.
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].kind <= in_data.kind;
      if (!in_data.kind) begin
        st[0].st  <= {in_data.block_hi, in_data.block_lo} ^ key[255:128];
        st[0].key <= key;
        st[0].rc  <= RconFirst;
      end else begin
        st[0].st  <= sub_inv(shift_rows({in_data.block_hi, in_data.block_lo}
                     ^ kc[SchedSteps][255:128], 3));
        st[0].key <= kc[SchedSteps];
        st[0].rc  <= RconLast;
      end
    end
  end

  for (genvar g = 0; g < NumStages - 1; g++) begin : g_rnd
    aesc_round_cell u_rc (
      .clk (clk),
      .en  (adv),
      .last(g == NumStages - 2),
      .odd (g % 2 == 0),
      .d   (st[g]),
      .q   (st[g+1])
    );
  end

  // Valid bits travel with the cells; only accepted requests enter.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], in_valid && !in_stall};
    end
  end

  assign out_valid = vld[NumStages-1];
  assign out_data  = st[NumStages-1].st;

endmodule
`default_nettype wire

>>> hw/rtl/aesc_checker.sv
// Port-level checks for the AES engine, bound to the top level.
// Depends on aesc_pkg.
`default_nettype none
module aesc_checker
  import aesc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire out_req_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while the output is blocked");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With the output free meanwhile, an accepted request reaches the last cell.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 (!out_stall)[*14] |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind aes_block_encrypt_decrypt_top aesc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

>>> test/aes_block_encrypt_decrypt_top_tb.sv
// Self-checking bench for the AES-256 ECB block engine.
// It depends on aesc_pkg and aes_block_encrypt_decrypt_top. Blocks without a listed
// result are predicted with the bench's own AES-256 cipher model built from scratch.
`default_nettype none
module aes_block_encrypt_decrypt_top_tb;
  import aesc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Key register indexes, plus the first index past the key words.
  localparam logic [KeyIdxW:0] KeyWord0    = 3'd0;
  localparam logic [KeyIdxW:0] KeyWord1    = 3'd1;
  localparam logic [KeyIdxW:0] KeyWord2    = 3'd2;
  localparam logic [KeyIdxW:0] KeyWord3    = 3'd3;
  localparam logic [KeyIdxW:0] KeyIdxSpare = 3'd4;
  localparam logic             Encrypt     = 1'b0;
  localparam logic             Decrypt     = 1'b1;
  localparam int unsigned      StallLimit  = 5000;
  localparam int unsigned      RandomItems = 700;
  localparam int unsigned      KeyPhases   = 5;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_req_t in_data;
  logic out_valid;
  logic out_stall;
  out_req_t out_data;
  logic cfg_we;
  logic [KeyIdxW:0] cfg_index;
  logic [63:0] cfg_data;

  aes_block_encrypt_decrypt_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Cipher model state: the key as the engine should hold it, and S-box tables.
  logic [63:0]  key_words [4];
  logic [7:0]   fwd_tab [256];
  logic [7:0]   inv_tab [256];
  out_req_t     cipher_q [$];
  int unsigned  err_count;
  int unsigned  accepted_blocks;
  int unsigned  checked_blocks;
  int unsigned  decrypt_blocks;
  int unsigned  key_writes;
  int unsigned  idle_cycles;
  logic         pending_known;
  out_req_t     pending_exp;
  logic         long_hold_go;
  logic         long_hold_done;

  // GF(2^8) multiply under the AES polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build both substitution tables from the field inverse and the affine map.
  task automatic build_sub_tables();
    logic [7:0] x;
    logic [7:0] y;
    for (int a = 0; a < 256; a++) begin
      x = 8'h01;
      for (int e = 0; e < 254; e++) x = gf_mul(x, a[7:0]);
      if (a == 0) x = 8'h00;
      y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ 8'h63;
      fwd_tab[a] = y;
      inv_tab[y] = a[7:0];
    end
  endtask

  function automatic logic [127:0] sub_state(input logic [127:0] s, input logic inv);
    for (int i = 0; i < 16; i++)
      s[127-8*i -: 8] = inv ? inv_tab[s[127-8*i -: 8]] : fwd_tab[s[127-8*i -: 8]];
    return s;
  endfunction

  // Byte n sits at row n mod 4, column n / 4; row r rotates left by r (or right).
  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 3 * r) % 4) : ((c + r) % 4);
        t[127-8*(c*4+r) -: 8] = s[127-8*(src*4+r) -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    logic [127:0] t;
    coef = inv ? '{8'h0e, 8'h0b, 8'h0d, 8'h09} : '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) col[j] = s[127-8*(c*4+j) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) acc ^= gf_mul(col[j], coef[(j - r + 4) % 4]);
        t[127-8*(c*4+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  // Full AES-256 of one block: expand the key into 15 round keys, then run the rounds.
  function automatic out_req_t aes_predict(input logic dir, input logic [127:0] blk);
    logic [31:0]  w [60];
    logic [31:0]  t;
    logic [7:0]   rcon;
    logic [127:0] rk [15];
    logic [127:0] s;
    out_req_t     res;
    rcon = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key_words[i/2][63-32*(i%2) -: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {fwd_tab[t[23:16]] ^ rcon, fwd_tab[t[15:8]], fwd_tab[t[7:0]], fwd_tab[t[31:24]]};
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    if (dir == Encrypt) begin
      s = blk ^ rk[0];
      for (int r = 1; r < 14; r++)
        s = mix_state(rotate_rows(sub_state(s, 1'b0), 1'b0), 1'b0) ^ rk[r];
      s = rotate_rows(sub_state(s, 1'b0), 1'b0) ^ rk[14];
    end else begin
      s = blk ^ rk[14];
      for (int r = 13; r > 0; r--)
        s = mix_state(sub_state(rotate_rows(s, 1'b1), 1'b1) ^ rk[r], 1'b1);
      s = sub_state(rotate_rows(s, 1'b1), 1'b1) ^ rk[0];
    end
    res.result_hi = s[127:64];
    res.result_lo = s[63:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %016h expected %016h", what, got, want);
    err_count++;
  endtask

  // Free-running clock; the single reset at the start is driven by the main sequence.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Accept requests, record their expected results, and check every result.
  always @(posedge clk) begin
    out_req_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        cipher_q.push_back(pending_known ? pending_exp
                           : aes_predict(in_data.kind, {in_data.block_hi, in_data.block_lo}));
        accepted_blocks++;
        if (in_data.kind == Decrypt) decrypt_blocks++;
      end
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("result_hi with no request waiting", out_data.result_hi, 64'h0);
        end else begin
          want = cipher_q.pop_front();
          if (out_data.result_hi !== want.result_hi)
            report_mismatch("result_hi", out_data.result_hi, want.result_hi);
          if (out_data.result_lo !== want.result_lo)
            report_mismatch("result_lo", out_data.result_lo, want.result_lo);
          checked_blocks++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog on cycles with no progress at all.
  always @(posedge clk) begin
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no progress for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stretches of free flow, random or alternating stalls, and one long hold-off.
  initial begin
    int mode;
    out_stall = 1'b1;
    long_hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        repeat (300) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 9) < 3);
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
        @(negedge clk);
      end
    end
  end

  // Offer one request and hold it until the engine takes it.
  task automatic send_block(input logic dir, input logic [63:0] hi, input logic [63:0] lo,
                            input logic known, input out_req_t want);
    int unsigned seen;
    pending_known = known;
    pending_exp = want;
    in_valid <= 1'b1;
    in_data <= '{kind: dir, block_hi: hi, block_lo: lo};
    seen = accepted_blocks;
    do @(negedge clk); while (accepted_blocks == seen);
    pending_known = 1'b0;
  endtask

  // Drop valid for a random gap at the end of a burst.
  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Wait until every result is back and the pipeline has gone quiet.
  task automatic drain_engine();
    in_valid <= 1'b0;
    @(negedge clk);
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Drive one register write for a cycle; the caller drops the enable.
  task automatic write_reg(input logic [KeyIdxW:0] idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    if (idx < KeyIdxSpare) key_words[idx[KeyIdxW-1:0]] = value;
    key_writes++;
  endtask

  // Load a whole key, with a stray out-of-range write first, then let the
  // final schedule state settle.
  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(KeyIdxSpare + 3'($urandom_range(0, 3)), {$urandom, $urandom});
    write_reg(KeyWord0, k0);
    write_reg(KeyWord1, k1);
    write_reg(KeyWord2, k2);
    write_reg(KeyWord3, k3);
    cfg_we <= 1'b0;
    repeat (12) @(negedge clk);
  endtask

  typedef struct {
    logic        new_key;
    logic        kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        known;
    logic [63:0] want_hi;
    logic [63:0] want_lo;
  } vector_t;

  // Directed vectors: zero key first, then the standard test key.
  localparam int NumVectors = 16;
  vector_t vectors [NumVectors] = '{
    '{1'b0, Encrypt, 64'h0, 64'h0, 1'b1, 64'hdc95c078a2408989, 64'had48a21492842087},
    '{1'b0, Decrypt, 64'hdc95c078a2408989, 64'had48a21492842087, 1'b1, 64'h0, 64'h0},
    '{1'b0, Encrypt, '1, '1, 1'b0, 64'h0, 64'h0},
    '{1'b0, Decrypt, '1, '1, 1'b0, 64'h0, 64'h0},
    '{1'b0, Decrypt, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{1'b0, Encrypt, 64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
    '{1'b0, Encrypt, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
    '{1'b0, Decrypt, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
    '{1'b1, Encrypt, 64'h0011223344556677, 64'h8899aabbccddeeff,
      1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
    '{1'b0, Decrypt, 64'h8ea2b7ca516745bf, 64'heafc49904b496089,
      1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff},
    '{1'b0, Encrypt, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{1'b0, Decrypt, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{1'b0, Encrypt, '1, '1, 1'b0, 64'h0, 64'h0},
    '{1'b0, Decrypt, '1, '1, 1'b0, 64'h0, 64'h0},
    '{1'b0, Encrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
    '{1'b0, Decrypt, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0}
  };

  // Main sequence: reset, directed vectors, then random phases under new keys.
  initial begin
    logic dir;
    int unsigned burst;
    int unsigned phase_items;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = KeyWord0;
    cfg_data = 64'h0;
    err_count = 0;
    accepted_blocks = 0;
    checked_blocks = 0;
    decrypt_blocks = 0;
    key_writes = 0;
    pending_known = 1'b0;
    pending_exp = '0;
    long_hold_go = 1'b0;
    for (int i = 0; i < 4; i++) key_words[i] = 64'h0;
    build_sub_tables();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, back to back within each key.
    foreach (vectors[i]) begin
      if (vectors[i].new_key) begin
        drain_engine();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      end
      send_block(vectors[i].kind, vectors[i].hi, vectors[i].lo, vectors[i].known,
                 '{result_hi: vectors[i].want_hi, result_lo: vectors[i].want_lo});
    end

    // Random part: first phase under an all-ones key, the rest under random keys.
    for (int p = 0; p < KeyPhases; p++) begin
      drain_engine();
      if (p == 0) begin
        load_key('1, '1, '1, '1);
      end else begin
        load_key({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      end
      phase_items = 0;
      while (phase_items < RandomItems / KeyPhases) begin
        burst = $urandom_range(1, 30);
        while (burst > 0 && phase_items < RandomItems / KeyPhases) begin
          if (p == 2 && phase_items == 20) long_hold_go = 1'b1;
          dir = 1'($urandom_range(0, 1));
          send_block(dir, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);
          burst--;
          phase_items++;
        end
        sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
    end

    drain_engine();
    $display("Checked %0d blocks (%0d decrypts) across %0d key settings, %0d register writes.",
             checked_blocks, decrypt_blocks, KeyPhases + 2, key_writes);
    $display("Directed vectors plus random bursts, with one long output hold-off.");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/aesc_pkg.sv
hw/rtl/aesc_key_cell.sv
hw/rtl/aesc_round_cell.sv
hw/rtl/aes_block_encrypt_decrypt_top.sv
hw/rtl/aesc_checker.sv
test/aes_block_encrypt_decrypt_top_tb.sv
